// ===== sv/allocation_region_tracker_top_assert.svh =====
// ----------------------------------------------------------------------------
// allocation region tracker assertion macros
// concurrent assertion wrappers, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_REGION_TRACKER_TOP_ASSERT_SVH
`define ALLOCATION_REGION_TRACKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ART_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ART_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ART_ASSERT_IMP(label, clk, rst_n, a, c)
`define ART_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// shared types and codes of the allocation region tracker
// ----------------------------------------------------------------------------
package art_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_UNMAP = 2'd2,
    ACT_UNMAP3 = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_ADDED    = 4'd0,
    ST_DUP      = 4'd1,
    ST_REMOVED  = 4'd2,
    ST_FRONT    = 4'd3,
    ST_TAIL     = 4'd4,
    ST_SPLIT    = 4'd5,
    ST_NOTFOUND = 4'd6,
    ST_FULL     = 4'd7,
    ST_OVERRUN  = 4'd8
  } status_e;

  // classified request passed from front to back
  typedef struct packed {
    logic        is_alloc;
    logic        is_free;
    logic [63:0] start;
    logic [63:0] size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] entry_start;
    logic [63:0] entry_size;
    logic [6:0]  live_count;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_SCAN2,
    BK_APPLY,
    BK_OUT
  } back_state_e;

endpackage

// ===== sv/art_front.sv =====
// ----------------------------------------------------------------------------
// art_front
// input stage: decodes an item and holds it in a two-entry queue
// ----------------------------------------------------------------------------
module art_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [1:0]      action_i,
  input  logic [63:0]     start_i,
  input  logic [63:0]     size_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output art_pkg::req_t   q_req_o
);
  import art_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       in_req;
  logic       push, pop;

  always_comb begin
    in_req.is_alloc = (action_i == ACT_ALLOC);
    in_req.is_free  = (action_i == ACT_FREE);
    in_req.start    = start_i;
    in_req.size     = (action_i == ACT_FREE) ? 64'd0 : size_i;
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/art_back.sv =====
// ----------------------------------------------------------------------------
// art_back
// table engine: scans entries one per cycle, updates, registers result
// ----------------------------------------------------------------------------
module art_back #(
  parameter int unsigned TableEntries = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  art_pkg::req_t   q_req_i,
  output logic            r_valid_o,
  input  logic            r_ready_i,
  output art_pkg::rsp_t   r_rsp_o
);
  import art_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [63:0]     base_mem [TableEntries];
  logic [63:0]     len_mem  [TableEntries];
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0] live_q;

  back_state_e     state_q, state_d;
  req_t            req_q;
  logic [IdxW:0]   idx_q;
  logic [63:0]     rd_base_q, rd_len_q;
  logic            rd_v_q;
  logic [IdxW-1:0] rd_idx_q;

  logic            hit_q, free_ok_q, tail_dup_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [63:0]     hb_q, hl_q, tail_s_q, tail_l_q, off_q;
  rsp_t            rsp_q, rsp_d;
  logic            tail_wr_q;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [63:0]     wr_base, wr_len;
  logic            rd_en;
  logic [63:0]     off_d;
  logic            match;

  assign q_ready_o = (state_q == BK_IDLE);
  assign r_valid_o = (state_q == BK_OUT);
  assign r_rsp_o   = rsp_q;

  // registered table read
  assign rd_en = (state_q == BK_SCAN || state_q == BK_SCAN2) &&
                 (idx_q < (IdxW+1)'(TableEntries));
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_base_q <= base_mem[idx_q[IdxW-1:0]];
      rd_len_q  <= len_mem[idx_q[IdxW-1:0]];
      rd_idx_q  <= idx_q[IdxW-1:0];
    end
    if (wr_en) begin
      base_mem[wr_idx] <= wr_base;
      len_mem[wr_idx]  <= wr_len;
    end
  end

  assign off_d = req_q.start - rd_base_q;
  always_comb begin
    if (state_q == BK_SCAN2) begin
      match = rd_v_q && (rd_base_q == tail_s_q);
    end else if (req_q.is_alloc) begin
      match = rd_v_q && (rd_base_q == req_q.start);
    end else begin
      match = rd_v_q && ((rd_base_q == req_q.start) ||
              ((req_q.start > rd_base_q) && (off_d < rd_len_q)));
    end
  end

  logic [63:0] lmo;
  assign lmo = hl_q - off_q;

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_idx  = hit_idx_q;
    wr_base = hb_q;
    wr_len  = hl_q;
    rsp_d   = rsp_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_SCAN;
      BK_SCAN: if (idx_q == (IdxW+1)'(TableEntries)) state_d = BK_DECIDE;
      BK_DECIDE: begin
        state_d = BK_OUT;
        rsp_d.live_count = 7'(live_q);
        if (req_q.is_alloc) begin
          if (hit_q) begin
            rsp_d.status = ST_DUP; rsp_d.entry_start = hb_q;
            rsp_d.entry_size = hl_q;
          end else if (!free_ok_q) begin
            rsp_d.status = ST_FULL; rsp_d.entry_start = req_q.start;
            rsp_d.entry_size = req_q.size;
          end else begin
            state_d = BK_APPLY;
          end
        end else if (!hit_q) begin
          rsp_d.status = ST_NOTFOUND; rsp_d.entry_start = req_q.start;
          rsp_d.entry_size = req_q.size;
        end else if (hb_q == req_q.start) begin
          if (req_q.is_free || req_q.size == hl_q) begin
            state_d = BK_APPLY;
          end else if (req_q.size > hl_q) begin
            rsp_d.status = ST_OVERRUN; rsp_d.entry_start = hb_q;
            rsp_d.entry_size = hl_q;
          end else begin
            state_d = BK_APPLY;
          end
        end else if (req_q.size > lmo) begin
          rsp_d.status = ST_OVERRUN; rsp_d.entry_start = hb_q;
          rsp_d.entry_size = hl_q;
        end else if (req_q.size == lmo) begin
          state_d = BK_APPLY;
        end else begin
          state_d = BK_SCAN2;
        end
      end
      BK_SCAN2: if (idx_q == (IdxW+1)'(TableEntries)) state_d = BK_APPLY;
      BK_APPLY: begin
        state_d = BK_OUT;
        rsp_d.live_count = 7'(live_q);
        if (req_q.is_alloc) begin
          wr_en = 1'b1; wr_idx = free_idx_q;
          wr_base = req_q.start; wr_len = req_q.size;
          rsp_d.status = ST_ADDED; rsp_d.entry_start = req_q.start;
          rsp_d.entry_size = req_q.size;
          rsp_d.live_count = 7'(live_q + 1'b1);
        end else if (hb_q == req_q.start) begin
          if (req_q.is_free || req_q.size == hl_q) begin
            rsp_d.status = ST_REMOVED; rsp_d.entry_start = hb_q;
            rsp_d.entry_size = hl_q;
            rsp_d.live_count = 7'(live_q - 1'b1);
          end else begin
            wr_en = 1'b1;
            wr_base = hb_q + req_q.size; wr_len = hl_q - req_q.size;
            rsp_d.status = ST_FRONT; rsp_d.entry_start = wr_base;
            rsp_d.entry_size = wr_len;
          end
        end else if (req_q.size == lmo) begin
          wr_en = 1'b1; wr_len = off_q;
          rsp_d.status = ST_TAIL; rsp_d.entry_start = hb_q;
          rsp_d.entry_size = off_q;
        end else if (!tail_dup_q && !free_ok_q) begin
          rsp_d.status = ST_FULL; rsp_d.entry_start = hb_q;
          rsp_d.entry_size = hl_q;
        end else begin
          wr_en = 1'b1; wr_len = off_q;
          rsp_d.status = ST_SPLIT; rsp_d.entry_start = hb_q;
          rsp_d.entry_size = off_q;
          if (!tail_dup_q) rsp_d.live_count = 7'(live_q + 1'b1);
        end
      end
      BK_OUT: begin
        // split tail written while the result waits
        if (tail_wr_q) begin
          wr_en = 1'b1; wr_idx = free_idx_q;
          wr_base = tail_s_q; wr_len = tail_l_q;
        end
        if (r_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      live_q    <= '0;
      idx_q     <= '0;
      rd_v_q    <= 1'b0;
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      tail_dup_q <= 1'b0;
      tail_wr_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tail_wr_q <= 1'b0;
      rd_v_q    <= rd_en && valid_q[idx_q[IdxW-1:0]];
      if (state_q == BK_IDLE && q_valid_i) begin
        idx_q <= '0; hit_q <= 1'b0; free_ok_q <= 1'b0;
      end
      if (state_q == BK_DECIDE) begin
        idx_q <= '0; tail_dup_q <= 1'b0;
      end
      if (state_q == BK_SCAN || state_q == BK_SCAN2) begin
        if (idx_q != (IdxW+1)'(TableEntries)) idx_q <= idx_q + 1'b1;
      end
      if (rd_en && !valid_q[idx_q[IdxW-1:0]] && !free_ok_q &&
          state_q == BK_SCAN) begin
        free_ok_q <= 1'b1;
      end
      if ((state_q == BK_SCAN || state_q == BK_DECIDE) && match &&
          (!hit_q || rd_base_q < hb_q)) begin
        hit_q <= 1'b1;
      end
      if (state_q == BK_SCAN2 && match) tail_dup_q <= 1'b1;
      if (state_q == BK_APPLY) begin
        if (req_q.is_alloc) begin
          valid_q[free_idx_q] <= 1'b1; live_q <= live_q + 1'b1;
        end else if (hb_q == req_q.start) begin
          if (req_q.is_free || req_q.size == hl_q) begin
            valid_q[hit_idx_q] <= 1'b0; live_q <= live_q - 1'b1;
          end
        end else if (req_q.size != lmo && !tail_dup_q && free_ok_q) begin
          valid_q[free_idx_q] <= 1'b1; live_q <= live_q + 1'b1;
          tail_wr_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == BK_IDLE && q_valid_i) req_q <= q_req_i;
    if (rd_en && !valid_q[idx_q[IdxW-1:0]] && !free_ok_q && state_q == BK_SCAN) begin
      free_idx_q <= idx_q[IdxW-1:0];
    end
    if ((state_q == BK_SCAN || state_q == BK_DECIDE) && match &&
        (!hit_q || rd_base_q < hb_q)) begin
      hit_idx_q <= rd_idx_q; hb_q <= rd_base_q; hl_q <= rd_len_q;
      off_q <= off_d;
    end
    if (state_q == BK_DECIDE) begin
      tail_s_q <= req_q.start + req_q.size;
      tail_l_q <= hl_q - req_q.size - off_q;
    end
  end
endmodule

// ===== sv/allocation_region_tracker_top.sv =====
// ----------------------------------------------------------------------------
// allocation_region_tracker_top
// live region table with allocate, free and unmap handling
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                 tuser
// s_axis   in   start_address[63:0], region_size[127:64]  action[1:0]
// m_axis   out  entry_start, entry_size, live_count       status[3:0]
//
// an item walks the table memory one entry per cycle, then is decided and,
// when the table may change, applied; a split adds a second walk of the
// table before it is applied
// reset clears the valid bits at once, no clearing pass
// a two-deep input queue takes up to two items while the engine works or
// its result waits
`include "allocation_region_tracker_top_assert.svh"
module allocation_region_tracker_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // start_address, region_size
  input  logic [1:0]    s_axis_tuser,  // action
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,  // entry_start, entry_size, live_count, pad
  output logic [3:0]    m_axis_tuser   // status
);
  import art_pkg::*;

  logic  q_valid, q_ready;
  req_t  q_req;
  rsp_t  rsp;

  art_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser),
    .start_i   (s_axis_tdata[63:0]),
    .size_i    (s_axis_tdata[127:64]),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_req_o   (q_req)
  );

  art_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_req_i   (q_req),
    .r_valid_o (m_axis_tvalid),
    .r_ready_i (m_axis_tready),
    .r_rsp_o   (rsp)
  );

  assign m_axis_tdata = {1'b0, rsp.live_count, rsp.entry_size, rsp.entry_start};
  assign m_axis_tuser = rsp.status;

  `ART_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `ART_ASSERT_IMP(a_live_range, clk_i, rst_ni, m_axis_tvalid,
                  32'(m_axis_tdata[134:128]) <= TABLE_ENTRIES)
  `ART_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, q_valid && q_ready, !m_axis_tvalid)
endmodule

// ===== tb/allocation_region_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// allocation_region_tracker_checker
// watches both stream channels of the region tracker, predicts the result
// of every accepted request from its own copy of the region table and
// compares each result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module allocation_region_tracker_checker #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // start_address, region_size
  input  logic [1:0]    s_axis_tuser,  // action
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [135:0]  m_axis_tdata,  // entry_start, entry_size, live_count, pad
  input  logic [3:0]    m_axis_tuser,  // status
  output int            pending_o,
  output int            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  logic        region_live [TABLE_ENTRIES];
  logic [63:0] region_base [TABLE_ENTRIES];
  logic [63:0] region_len  [TABLE_ENTRIES];
  int unsigned live_total;
  rsp_t        expected_rsp_q [$];
  int          fail_count;

  assign pending_o    = expected_rsp_q.size();
  assign fail_count_o = fail_count;

  initial begin
    fail_count = 0;
    live_total = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      region_live[i] = 1'b0;
      region_base[i] = '0;
      region_len[i]  = '0;
    end
  end

  function automatic int slot_with_start(logic [63:0] s);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (region_live[i] && region_base[i] == s) return i;
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!region_live[i]) return i;
    return -1;
  endfunction

  function automatic rsp_t pack_rsp(status_e st, logic [63:0] s, logic [63:0] z);
    rsp_t o;
    o.status      = st;
    o.entry_start = s;
    o.entry_size  = z;
    o.live_count  = live_total[6:0];
    return o;
  endfunction

  function automatic rsp_t apply_region_request(logic [1:0] act, logic [63:0] s,
                                                logic [63:0] r);
    int e;
    int f;
    logic [63:0] b;
    logic [63:0] l;
    logic [63:0] off;
    if (act == ACT_ALLOC) begin
      e = slot_with_start(s);
      if (e >= 0) return pack_rsp(ST_DUP, region_base[e], region_len[e]);
      f = first_free_slot();
      if (f < 0) return pack_rsp(ST_FULL, s, r);
      region_live[f] = 1'b1;
      region_base[f] = s;
      region_len[f]  = r;
      live_total++;
      return pack_rsp(ST_ADDED, s, r);
    end
    if (act == ACT_FREE) r = '0;
    e = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (region_live[i] && (region_base[i] == s ||
          (s > region_base[i] && s - region_base[i] < region_len[i])))
        if (e < 0 || region_base[i] < region_base[e]) e = i;
    end
    if (e < 0) return pack_rsp(ST_NOTFOUND, s, r);
    b = region_base[e];
    l = region_len[e];
    if (s == b) begin
      if (act == ACT_FREE || r == l) begin
        region_live[e] = 1'b0;
        live_total--;
        return pack_rsp(ST_REMOVED, b, l);
      end
      if (r > l) return pack_rsp(ST_OVERRUN, b, l);
      region_base[e] = b + r;
      region_len[e]  = l - r;
      return pack_rsp(ST_FRONT, b + r, l - r);
    end
    off = s - b;
    if (r > l - off) return pack_rsp(ST_OVERRUN, b, l);
    if (r == l - off) begin
      region_len[e] = off;
      return pack_rsp(ST_TAIL, b, off);
    end
    if (slot_with_start(s + r) < 0) begin
      f = first_free_slot();
      if (f < 0) return pack_rsp(ST_FULL, b, l);
      region_live[f] = 1'b1;
      region_base[f] = s + r;
      region_len[f]  = l - r - off;
      live_total++;
    end
    region_len[e] = off;
    return pack_rsp(ST_SPLIT, b, off);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_rsp_q.push_back(apply_region_request(s_axis_tuser,
          s_axis_tdata[63:0], s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", {60'd0, m_axis_tuser}, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", {60'd0, m_axis_tuser}, {60'd0, want.status});
          if (m_axis_tdata[63:0] != want.entry_start)
            report_mismatch("entry_start", m_axis_tdata[63:0], want.entry_start);
          if (m_axis_tdata[127:64] != want.entry_size)
            report_mismatch("entry_size", m_axis_tdata[127:64], want.entry_size);
          if (m_axis_tdata[134:128] != want.live_count)
            report_mismatch("live_count", {57'd0, m_axis_tdata[134:128]},
                            {57'd0, want.live_count});
        end
      end
    end
  end

endmodule

// ===== tb/allocation_region_tracker_top_tb.sv =====
// ----------------------------------------------------------------------------
// allocation_region_tracker_top_tb
// drives directed and random allocate, free and unmap requests into the
// region tracker under varying idle patterns; the checker beside the block
// predicts and compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
module allocation_region_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int IDLE_LIMIT = 30000;

  typedef struct {
    logic [63:0] s;
    logic [63:0] z;
  } region_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;  // start_address, region_size
  logic [1:0]    s_axis_tuser = '0;  // action
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;  // entry_start, entry_size, live_count, pad
  logic [3:0]    m_axis_tuser;  // status
  int            pending;
  int            fail_count;
  int            tx_idle_pct = 11;
  int            rx_idle_pct = 63;
  int            idle_cycles = 0;
  region_t       alloc_pool [$];

  always #6 clk_i = ~clk_i;

  allocation_region_tracker_top dut (.*);

  allocation_region_tracker_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [63:0] s, logic [63:0] z);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {z, s};
    if (act == ACT_ALLOC) begin
      alloc_pool.push_back('{s, z});
      if (alloc_pool.size() > 96) void'(alloc_pool.pop_front());
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random();
    region_t p;
    int kind;
    logic [63:0] off;
    logic [63:0] z;
    kind = $urandom_range(99);
    if (kind < 10 || alloc_pool.size() == 0) begin
      send(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom});
    end else if (kind < (tx_idle_pct == 0 ? 50 : 60)) begin
      send(ACT_ALLOC, 64'($urandom_range(255)) * 64'd64, 64'($urandom_range(1, 96)));
    end else begin
      p = alloc_pool[$urandom_range(alloc_pool.size() - 1)];
      off = (p.z > 1 && $urandom_range(1)) ?
            64'($urandom_range(1, 32'(p.z - 1))) : '0;
      case ($urandom_range(4))
        0: z = p.z - off;
        1: z = (p.z - off > 1) ? 64'($urandom_range(0, 32'(p.z - off - 1))) : '0;
        2: z = p.z - off + 64'($urandom_range(1, 8));
        default: z = 64'($urandom_range(0, 16));
      endcase
      send($urandom_range(3) == 0 ? ACT_FREE : ($urandom_range(7) == 0 ? ACT_UNMAP3
           : ACT_UNMAP), p.s + off, z);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(ACT_ALLOC, 64'h0, 64'h0);
    send(ACT_ALLOC, '1, '1);
    send(ACT_ALLOC, '1, 64'h5);
    send(ACT_FREE, 64'h0, '1);
    send(ACT_ALLOC, 64'h1000, 64'h100);
    send(ACT_UNMAP, 64'h1000, 64'h200);
    send(ACT_UNMAP, 64'h1000, 64'h0);
    send(ACT_UNMAP, 64'h1000, 64'h40);
    send(ACT_UNMAP, 64'h1100, 64'h0);
    send(ACT_UNMAP, 64'h1080, 64'h80);
    send(ACT_UNMAP, 64'h1050, 64'h40);
    send(ACT_UNMAP3, 64'h1060, 64'h10);
    send(ACT_FREE, 64'h1044, 64'h0);
    send(ACT_UNMAP, 64'h1048, 64'h1000);
    send(ACT_ALLOC, 64'h2000, 64'h100);
    send(ACT_ALLOC, 64'h2080, 64'h10);
    send(ACT_UNMAP, 64'h2040, 64'h40);
    send(ACT_UNMAP, 64'h2000, 64'h40);
    send(ACT_UNMAP, 64'hdead_0000, 64'h8);
    send(ACT_FREE, 64'h1040, 64'h0);
    send(ACT_UNMAP, 64'h1000, 64'h0);
    send(ACT_ALLOC, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    send(ACT_UNMAP, 64'hffff_ffff_ffff_fff0, 64'h8);
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 63 : 0;
      rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 11 : 0;
      for (int n = 0; n < 360; n++) begin
        send_random();
        if (ph == 1 && n == 100) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending != 0);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
